[sv/adgu_pkg.sv]
// Shared widths, constants, register indexes and helpers for the AdaGrad weight updater.
`timescale 1ns / 1ps
package adgu_pkg;

  localparam int GRAD_W     = 32;
  localparam int SUM_W      = 63;
  localparam int SHADOW_W   = 40;
  localparam int RATE_W     = 24;
  localparam int EPOCH_W    = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int MAG_W      = 32;
  localparam int RAD_W      = 64;
  localparam int SQRT_W     = 32;
  localparam int ETA_QW     = 24;
  localparam int PROD_W     = RATE_W + EPOCH_W;
  localparam int NUM_W      = RATE_W + MAG_W;
  localparam int DEN_W      = SQRT_W + 3;
  localparam int RND_W      = NUM_W + 1;
  // root >= 65, so the rounded quotient stays below 2^51
  localparam int DIV_QW     = 51;

  localparam logic [RATE_W-1:0] RATE_DEFAULT = 24'd1966080;  // 30.0 in Q8.16
  localparam logic [RAD_W-1:0]  EPS_Q32      = 64'd4295;     // 1e-6 in Q.32

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RATE_START   = 3'd0,
    CFG_RATE_MIDDLE  = 3'd1,
    CFG_RATE_END     = 3'd2,
    CFG_FIRST_BREAK  = 3'd3,
    CFG_SECOND_BREAK = 3'd4,
    CFG_EPOCH        = 3'd5
  } cfg_idx_t;

  // a rate register of zero stands for 30.0
  function automatic logic [RATE_W-1:0] eff_rate(input logic [RATE_W-1:0] r);
    return (r == '0) ? RATE_DEFAULT : r;
  endfunction

endpackage

[sv/adgu_if.sv]
// Valid/ready channel interfaces for the updater's input and result streams.
`timescale 1ns / 1ps
interface adgu_in_if import adgu_pkg::*; #(parameter int WEIGHT_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic signed [GRAD_W-1:0]    gradient;
  logic [SUM_W-1:0]            sq_sum_in;
  logic signed [SHADOW_W-1:0]  shadow_in;
  logic                        shadow_valid;
  logic signed [WEIGHT_BITS-1:0] weight_in;
  logic                        rate_eighth;

  modport source (output valid, gradient, sq_sum_in, shadow_in, shadow_valid, weight_in,
                  rate_eighth, input ready);
  modport sink   (input valid, gradient, sq_sum_in, shadow_in, shadow_valid, weight_in,
                  rate_eighth, output ready);
endinterface

interface adgu_out_if import adgu_pkg::*; #(parameter int WEIGHT_BITS = 16);
  logic                          valid;
  logic                          ready;
  logic signed [WEIGHT_BITS-1:0] weight_out;
  logic [SUM_W-1:0]              sq_sum_out;
  logic signed [SHADOW_W-1:0]    shadow_out;
  logic                          shadow_valid_out;
  logic                          updated;

  modport source (output valid, weight_out, sq_sum_out, shadow_out, shadow_valid_out,
                  updated, input ready);
  modport sink   (input valid, weight_out, sq_sum_out, shadow_out, shadow_valid_out,
                  updated, output ready);
endinterface

[sv/adagrad_weight_update.sv]
// Top level: fully pipelined per-weight AdaGrad update with scheduled learning rate.
`timescale 1ns / 1ps
// Usage
//   in_ch  : one weight per transfer (gradient, squared-gradient sum, shadow value and
//            its valid flag, quantized weight, one-eighth rate select).
//   out_ch : one result per input transfer, in order (weight, sum, shadow, flags).
//   cfg_*  : write-only registers, rates and schedule epochs; write only while no item
//            is in flight. Unused indexes are ignored.
// From input transfer to output valid an item passes 3 front stages (magnitude,
// square, saturating sum, epsilon; schedule select and ramp product), 32 square-root
// stages that resolve one root bit each (the ramp quotient resolves in the first 24
// of them), 3 stages forming eta*|g| and the rounded dividend, 51 divide stages at one
// quotient bit each, then update, clamp and round.
// Throughput is one item per cycle; the whole pipeline moves together on one enable.
// When out_ch stalls every stage holds, in_ch.ready drops in the same cycle and no
// item is lost or repeated; bubbles move up as soon as the output is taken.
// Synchronous reset clears the stage valid bits and restores the register defaults
// (rates 30.0, epochs 0); data registers are not reset.
module adagrad_weight_update import adgu_pkg::*; #(
  parameter int WEIGHT_BITS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  adgu_in_if.sink               in_ch,
  adgu_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_idx,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int WB  = WEIGHT_BITS;
  localparam int NST = 3 + SQRT_W + 3 + DIV_QW + 3;

  // clamp limits in Q.16, bounded by the shadow range
  localparam logic signed [63:0] WMAX_Q     = ((64'sd1 <<< (WB - 1)) - 64'sd1) <<< 16;
  localparam logic signed [63:0] WMIN_Q     = -(64'sd1 <<< (WB - 1)) <<< 16;
  localparam logic signed [63:0] SHADOW_MAX = (64'sd1 <<< (SHADOW_W - 1)) - 64'sd1;
  localparam logic signed [63:0] SHADOW_MIN = -(64'sd1 <<< (SHADOW_W - 1));
  localparam logic signed [63:0] LIM_HI     = (WMAX_Q > SHADOW_MAX) ? SHADOW_MAX : WMAX_Q;
  localparam logic signed [63:0] LIM_LO     = (WMIN_Q < SHADOW_MIN) ? SHADOW_MIN : WMIN_Q;

  // sideband carried through every stage
  typedef struct packed {
    logic                       zero;
    logic                       neg;
    logic                       sv;
    logic                       eighth;
    logic signed [WB-1:0]       weight;
    logic signed [SHADOW_W-1:0] shadow;
    logic [MAG_W-1:0]           mag;
  } sb_t;

  typedef struct packed {
    sb_t                sb;
    logic [SUM_W-1:0]   sum;
    logic [RAD_W-1:0]   wide;   // square in stage 1, radicand in stage 3
    logic [RATE_W-1:0]  ebase;
    logic               eneg;
    logic [RATE_W-1:0]  adiff;
    logic [EPOCH_W-1:0] eoff;
    logic [PROD_W-1:0]  eprod;
    logic [EPOCH_W-1:0] ediv;
  } fr_t;

  typedef struct packed {
    sb_t                sb;
    logic [SUM_W-1:0]   sum;
    logic [RAD_W-1:0]   x;
    logic [SQRT_W-1:0]  r;
    logic [RATE_W-1:0]  ebase;
    logic               eneg;
    logic [PROD_W-1:0]  erem;
    logic [ETA_QW-1:0]  eq;
    logic [EPOCH_W-1:0] ediv;
  } sq_t;

  typedef struct packed {
    sb_t               sb;
    logic [SUM_W-1:0]  sum;
    logic [SQRT_W-1:0] root;
    logic [RATE_W-1:0] eta;
  } m1_t;

  typedef struct packed {
    sb_t              sb;
    logic [SUM_W-1:0] sum;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } m2_t;

  typedef struct packed {
    sb_t               sb;
    logic [SUM_W-1:0]  sum;
    logic [RND_W-1:0]  rem;
    logic [DEN_W-1:0]  den;
    logic [DIV_QW-1:0] q;
  } dv_t;

  typedef struct packed {
    sb_t                sb;
    logic [SUM_W-1:0]   sum;
    logic signed [63:0] v;
  } f1_t;

  typedef struct packed {
    sb_t                        sb;
    logic [SUM_W-1:0]           sum;
    logic signed [SHADOW_W-1:0] vc;
  } f2_t;

  // ---------------------------------------------------------------- config
  logic [RATE_W-1:0]  rate_start_r, rate_middle_r, rate_end_r;
  logic [EPOCH_W-1:0] first_break_r, second_break_r, epoch_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_start_r   <= RATE_DEFAULT;
      rate_middle_r  <= RATE_DEFAULT;
      rate_end_r     <= RATE_DEFAULT;
      first_break_r  <= '0;
      second_break_r <= '0;
      epoch_r        <= '0;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_RATE_START:   rate_start_r   <= cfg_wdata[RATE_W-1:0];
        CFG_RATE_MIDDLE:  rate_middle_r  <= cfg_wdata[RATE_W-1:0];
        CFG_RATE_END:     rate_end_r     <= cfg_wdata[RATE_W-1:0];
        CFG_FIRST_BREAK:  first_break_r  <= cfg_wdata[EPOCH_W-1:0];
        CFG_SECOND_BREAK: second_break_r <= cfg_wdata[EPOCH_W-1:0];
        CFG_EPOCH:        epoch_r        <= cfg_wdata[EPOCH_W-1:0];
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------- control
  logic           adv;      // whole pipe moves
  logic           in_xfer;
  logic [NST-1:0] vld_r;

  assign adv         = !vld_r[NST-1] || out_ch.ready;
  assign in_ch.ready = adv;
  assign in_xfer     = in_ch.valid && adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[NST-2:0], in_xfer};
    end
  end

  // ---------------------------------------------------------------- stage 1
  // magnitude and square of g; pick the schedule segment
  fr_t s1_r, s1_nxt;
  logic [RATE_W-1:0] e1, e2, e3;
  logic [RATE_W:0]   ed;

  assign e1 = eff_rate(rate_start_r);
  assign e2 = eff_rate(rate_middle_r);
  assign e3 = eff_rate(rate_end_r);

  always_comb begin
    s1_nxt           = '0;
    s1_nxt.sb.zero   = (in_ch.gradient == '0);
    s1_nxt.sb.neg    = in_ch.gradient[GRAD_W-1];
    s1_nxt.sb.sv     = in_ch.shadow_valid;
    s1_nxt.sb.eighth = in_ch.rate_eighth;
    s1_nxt.sb.weight = in_ch.weight_in;
    s1_nxt.sb.shadow = in_ch.shadow_in;
    s1_nxt.sb.mag    = in_ch.gradient[GRAD_W-1] ? (~in_ch.gradient + 32'd1) : in_ch.gradient;
    s1_nxt.sum       = in_ch.sq_sum_in;
    s1_nxt.wide      = s1_nxt.sb.mag * s1_nxt.sb.mag;
    s1_nxt.ediv      = 32'd1;
    ed               = '0;
    priority if (first_break_r == '0) begin
      s1_nxt.ebase = e1;
    end else if (epoch_r < first_break_r) begin
      s1_nxt.ebase = e1;
      ed           = {1'b0, e2} - {1'b0, e1};
      s1_nxt.eoff  = epoch_r;
      s1_nxt.ediv  = first_break_r;
    end else if (second_break_r == '0) begin
      s1_nxt.ebase = e2;
    end else if (epoch_r < second_break_r) begin
      s1_nxt.ebase = e2;
      ed           = {1'b0, e3} - {1'b0, e2};
      s1_nxt.eoff  = epoch_r - first_break_r;
      s1_nxt.ediv  = second_break_r - first_break_r;
    end else begin
      s1_nxt.ebase = e3;
    end
    s1_nxt.eneg  = ed[RATE_W];
    s1_nxt.adiff = ed[RATE_W] ? RATE_W'(-ed) : ed[RATE_W-1:0];
  end

  // ---------------------------------------------------------------- stage 2
  // saturating sum update; ramp numerator product
  fr_t s2_r, s2_nxt;
  logic [RAD_W-1:0] sum_ext;

  always_comb begin
    s2_nxt       = s1_r;
    sum_ext      = {1'b0, s1_r.sum} + s1_r.wide;
    s2_nxt.sum   = sum_ext[RAD_W-1] ? {SUM_W{1'b1}} : sum_ext[SUM_W-1:0];
    s2_nxt.eprod = s1_r.adiff * s1_r.eoff;
  end

  // ---------------------------------------------------------------- stage 3
  fr_t s3_r, s3_nxt;

  always_comb begin
    s3_nxt      = s2_r;
    s3_nxt.wide = {1'b0, s2_r.sum} + EPS_Q32;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_r <= s1_nxt;
      s2_r <= s2_nxt;
      s3_r <= s3_nxt;
    end
  end

  // ---------------------------------------------------------------- square root
  // one root bit per stage; the ramp quotient shares the first stages
  sq_t sq_in;
  sq_t sqrt_r [SQRT_W];

  always_comb begin
    sq_in       = '0;
    sq_in.sb    = s3_r.sb;
    sq_in.sum   = s3_r.sum;
    sq_in.x     = s3_r.wide;
    sq_in.ebase = s3_r.ebase;
    sq_in.eneg  = s3_r.eneg;
    sq_in.erem  = s3_r.eprod;
    sq_in.ediv  = s3_r.ediv;
  end

  for (genvar k = 0; k < SQRT_W; k++) begin : g_sqrt
    localparam int I = SQRT_W - 1 - k;
    localparam int J = (k < ETA_QW) ? (ETA_QW - 1 - k) : 0;
    sq_t         cur, stage_nxt;
    logic [65:0] trial;

    if (k == 0) begin : g_first
      assign cur = sq_in;
    end else begin : g_next
      assign cur = sqrt_r[k-1];
    end

    always_comb begin
      stage_nxt = cur;
      trial     = (66'(cur.r) << (I + 1)) + (66'd1 << (2 * I));
      if (66'(cur.x) >= trial) begin
        stage_nxt.x    = RAD_W'(66'(cur.x) - trial);
        stage_nxt.r[I] = 1'b1;
      end
      if (k < ETA_QW) begin
        if ((cur.erem >> J) >= PROD_W'(cur.ediv)) begin
          stage_nxt.erem  = cur.erem - (PROD_W'(cur.ediv) << J);
          stage_nxt.eq[J] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sqrt_r[k] <= stage_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- eta, numerator
  m1_t m1_r, m1_nxt;
  m2_t m2_r, m2_nxt;
  dv_t m3_r, m3_nxt;

  always_comb begin
    m1_nxt      = '0;
    m1_nxt.sb   = sqrt_r[SQRT_W-1].sb;
    m1_nxt.sum  = sqrt_r[SQRT_W-1].sum;
    m1_nxt.root = sqrt_r[SQRT_W-1].r;
    m1_nxt.eta  = sqrt_r[SQRT_W-1].eneg ? (sqrt_r[SQRT_W-1].ebase - sqrt_r[SQRT_W-1].eq)
                                        : (sqrt_r[SQRT_W-1].ebase + sqrt_r[SQRT_W-1].eq);
  end

  always_comb begin
    m2_nxt     = '0;
    m2_nxt.sb  = m1_r.sb;
    m2_nxt.sum = m1_r.sum;
    m2_nxt.num = m1_r.eta * m1_r.sb.mag;
    m2_nxt.den = m1_r.sb.eighth ? {m1_r.root, 3'b000} : DEN_W'(m1_r.root);
  end

  // add half the divisor for round-half-up
  always_comb begin
    m3_nxt     = '0;
    m3_nxt.sb  = m2_r.sb;
    m3_nxt.sum = m2_r.sum;
    m3_nxt.den = m2_r.den;
    m3_nxt.rem = RND_W'(m2_r.num) + RND_W'(m2_r.den >> 1);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m1_r <= m1_nxt;
      m2_r <= m2_nxt;
      m3_r <= m3_nxt;
    end
  end

  // ---------------------------------------------------------------- divider
  // restoring, one quotient bit per stage, MSB first
  dv_t div_r [DIV_QW];

  for (genvar k = 0; k < DIV_QW; k++) begin : g_div
    localparam int I = DIV_QW - 1 - k;
    dv_t cur, stage_nxt;

    if (k == 0) begin : g_first
      assign cur = m3_r;
    end else begin : g_next
      assign cur = div_r[k-1];
    end

    always_comb begin
      stage_nxt = cur;
      if ((cur.rem >> I) >= RND_W'(cur.den)) begin
        stage_nxt.rem  = cur.rem - (RND_W'(cur.den) << I);
        stage_nxt.q[I] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        div_r[k] <= stage_nxt;
      end
    end
  end

  // ---------------------------------------------------------------- update, clamp, round
  f1_t f1_r, f1_nxt;
  f2_t f2_r, f2_nxt;
  logic signed [63:0] base;

  always_comb begin
    f1_nxt     = '0;
    f1_nxt.sb  = div_r[DIV_QW-1].sb;
    f1_nxt.sum = div_r[DIV_QW-1].sum;
    base       = div_r[DIV_QW-1].sb.sv
               ? 64'(div_r[DIV_QW-1].sb.shadow)
               : (64'(div_r[DIV_QW-1].sb.weight) <<< 16);
    // delta takes the opposite sign of g
    f1_nxt.v   = div_r[DIV_QW-1].sb.neg ? (base + $signed(64'(div_r[DIV_QW-1].q)))
                                        : (base - $signed(64'(div_r[DIV_QW-1].q)));
  end

  always_comb begin
    f2_nxt     = '0;
    f2_nxt.sb  = f1_r.sb;
    f2_nxt.sum = f1_r.sum;
    priority if (f1_r.v > LIM_HI) begin
      f2_nxt.vc = SHADOW_W'(LIM_HI);
    end else if (f1_r.v < LIM_LO) begin
      f2_nxt.vc = SHADOW_W'(LIM_LO);
    end else begin
      f2_nxt.vc = SHADOW_W'(f1_r.v);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      f1_r <= f1_nxt;
      f2_r <= f2_nxt;
    end
  end

  // half away from zero on the magnitude
  logic [SHADOW_W:0]      vabs, vrnd, wv;
  logic signed [WB-1:0]   weight_nxt;
  logic signed [WB-1:0]   weight_r;
  logic [SUM_W-1:0]       sum_r;
  logic signed [SHADOW_W-1:0] shadow_r;
  logic                   svo_r, upd_r;

  always_comb begin
    vabs       = f2_r.vc[SHADOW_W-1] ? ((SHADOW_W+1)'(0) - {f2_r.vc[SHADOW_W-1], f2_r.vc})
                                     : {1'b0, f2_r.vc};
    vrnd       = (vabs + (SHADOW_W+1)'(32768)) >> 16;
    wv         = f2_r.vc[SHADOW_W-1] ? ((SHADOW_W+1)'(0) - vrnd) : vrnd;
    weight_nxt = f2_r.sb.zero ? f2_r.sb.weight : wv[WB-1:0];
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      weight_r <= weight_nxt;
      sum_r    <= f2_r.sum;
      shadow_r <= f2_r.sb.zero ? f2_r.sb.shadow : f2_r.vc;
      svo_r    <= f2_r.sb.zero ? f2_r.sb.sv : 1'b1;
      upd_r    <= !f2_r.sb.zero;
    end
  end

  assign out_ch.valid            = vld_r[NST-1];
  assign out_ch.weight_out       = weight_r;
  assign out_ch.sq_sum_out       = sum_r;
  assign out_ch.shadow_out       = shadow_r;
  assign out_ch.shadow_valid_out = svo_r;
  assign out_ch.updated          = upd_r;

  // ---------------------------------------------------------------- assertions
  a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.ready |-> !in_ch.ready)
    else $error("input accepted while output stalled");

  a_stall_freezes_pipe: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(vld_r))
    else $error("pipeline moved during stall");

  a_update_sets_shadow: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.updated |-> out_ch.shadow_valid_out)
    else $error("update without valid shadow");

endmodule
